>>> rtl/glu_pkg.sv
package glu_pkg;

   localparam int VALUE_BITS = 62;

   typedef struct packed {
      logic load;
      logic gcd_step;
      logic gcd_finish;
      logic div_step;
      logic mul_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic bad;
      logic mode;
      logic gcd_equal;
   } status_type;

endpackage

>>> rtl/glu_dpath.sv
module glu_dpath #(
   parameter int OPERAND_BITS = 31
) (
   input  logic                           clock,
   input  glu_pkg::cmd_type               cmd,
   output glu_pkg::status_type            status,
   input  logic                           req_mode,
   input  logic [OPERAND_BITS-1:0]        req_operand_a,
   input  logic [OPERAND_BITS-1:0]        req_operand_b,
   output logic [glu_pkg::VALUE_BITS-1:0] rsp_value,
   output logic                           rsp_bad_operand
);

   localparam int KW = $clog2(OPERAND_BITS + 1);
   localparam int PW = 2 * OPERAND_BITS;
   localparam int OB = OPERAND_BITS;

   logic                           mode_ff, mode_in;
   logic                           bad_ff, bad_in;
   logic [OB-1:0]                  a_ff, a_in;
   logic [OB-1:0]                  b_ff, b_in;
   logic [OB-1:0]                  x_ff, x_in;
   logic [OB-1:0]                  y_ff, y_in;
   logic [KW-1:0]                  k_ff, k_in;
   logic [OB-1:0]                  g_ff, g_in;
   logic [OB-1:0]                  rem_ff, rem_in;
   logic [OB-1:0]                  quo_ff, quo_in;
   logic [PW-1:0]                  prod_ff, prod_in;
   logic [glu_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic                           out_bad_ff, out_bad_in;
   logic [OB-1:0]                  diff_xy, diff_yx;
   logic [OB:0]                    trial, trial_diff;

   assign diff_xy    = x_ff - y_ff;
   assign diff_yx    = y_ff - x_ff;
   assign trial      = {rem_ff, quo_ff[OB-1]};
   assign trial_diff = trial - {1'b0, g_ff};

   always_comb begin
      mode_in    = mode_ff;
      bad_in     = bad_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      k_in       = k_ff;
      g_in       = g_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      prod_in    = prod_ff;
      value_in   = value_ff;
      out_bad_in = out_bad_ff;
      if (cmd.load) begin
         mode_in = req_mode;
         bad_in  = (req_operand_a == '0) || (req_operand_b == '0);
         a_in    = req_operand_a;
         b_in    = req_operand_b;
         x_in    = req_operand_a;
         y_in    = req_operand_b;
         k_in    = '0;
      end
      if (cmd.gcd_step) begin
         if (!x_ff[0] && !y_ff[0]) begin
            x_in = x_ff >> 1;
            y_in = y_ff >> 1;
            k_in = k_ff + KW'(1);
         end else if (!x_ff[0]) begin
            x_in = x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_in = y_ff >> 1;
         end else if (x_ff > y_ff) begin
            x_in = diff_xy >> 1;
         end else begin
            y_in = diff_yx >> 1;
         end
      end
      if (cmd.gcd_finish) begin
         g_in   = x_ff << k_ff;
         rem_in = '0;
         quo_in = a_ff;
      end
      if (cmd.div_step) begin
         if (!trial_diff[OB]) begin
            rem_in = trial_diff[OB-1:0];
            quo_in = {quo_ff[OB-2:0], 1'b1};
         end else begin
            rem_in = trial[OB-1:0];
            quo_in = {quo_ff[OB-2:0], 1'b0};
         end
      end
      if (cmd.mul_step) begin
         prod_in = PW'(quo_ff) * PW'(b_ff);
      end
      if (cmd.out_load) begin
         out_bad_in = bad_ff;
         if (bad_ff) begin
            value_in = '0;
         end else if (mode_ff) begin
            value_in = glu_pkg::VALUE_BITS'(prod_ff);
         end else begin
            value_in = glu_pkg::VALUE_BITS'(g_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      bad_ff     <= bad_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      k_ff       <= k_in;
      g_ff       <= g_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      prod_ff    <= prod_in;
      value_ff   <= value_in;
      out_bad_ff <= out_bad_in;
   end

   assign status.bad       = bad_ff;
   assign status.mode      = mode_ff;
   assign status.gcd_equal = (x_ff == y_ff);

   assign rsp_value       = value_ff;
   assign rsp_bad_operand = out_bad_ff;

endmodule

>>> rtl/glu_ctrl.sv
module glu_ctrl #(
   parameter int OPERAND_BITS = 31
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  glu_pkg::status_type status,
   output glu_pkg::cmd_type    cmd
);

   localparam int CW = $clog2(OPERAND_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIVIDE,
      ST_MULTIPLY,
      ST_WRITE
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (status.bad) begin
               state_in = ST_WRITE;
            end else if (status.gcd_equal) begin
               cmd.gcd_finish = 1'b1;
               cnt_in         = '0;
               state_in       = status.mode ? ST_DIVIDE : ST_WRITE;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CW'(1);
            if (cnt_ff == CW'(OPERAND_BITS - 1)) begin
               state_in = ST_MULTIPLY;
            end
         end
         ST_MULTIPLY: begin
            cmd.mul_step = 1'b1;
            state_in     = ST_WRITE;
         end
         ST_WRITE: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/gcd_lcm_unit.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_mode, req_operand_a, req_operand_b
// rsp_      out        rsp_valid/rsp_stall  rsp_value, rsp_bad_operand
//
// An item passes through a load, binary GCD steps, a GCD finish and a write (an item
// with a zero operand goes from the load straight to the write); in LCM mode divide
// steps and a multiply step are added.
// The iterative GCD loop and the one-bit-per-cycle divider set how long an item takes.
// Reset is synchronous and clears only the controller and the result valid flag.
// A held result under rsp_stall does not block the next transaction from entering.
module gcd_lcm_unit #(
   parameter int OPERAND_BITS = 31
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_mode,
   input  logic [OPERAND_BITS-1:0]        req_operand_a,
   input  logic [OPERAND_BITS-1:0]        req_operand_b,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [glu_pkg::VALUE_BITS-1:0] rsp_value,
   output logic                           rsp_bad_operand
);

   glu_pkg::cmd_type    cmd;
   glu_pkg::status_type status;

   glu_ctrl #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   glu_dpath #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_dpath (
      .clock          (clock),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_mode),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .rsp_value      (rsp_value),
      .rsp_bad_operand(rsp_bad_operand)
   );

endmodule

>>> rtl/glu_checker.sv
module glu_checker #(
   parameter int OPERAND_BITS = 31
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_mode,
   input logic [OPERAND_BITS-1:0]        req_operand_a,
   input logic [OPERAND_BITS-1:0]        req_operand_b,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [glu_pkg::VALUE_BITS-1:0] rsp_value,
   input logic                           rsp_bad_operand
);

   logic req_accept;

   assign req_accept = req_valid && !req_stall;

   a_bad_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_operand |-> rsp_value == '0)
      else $error("Bad operand transaction carries a non-zero value.");

   a_good_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_bad_operand |-> rsp_value != '0)
      else $error("Valid operand transaction gives a zero result.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> req_stall && !$rose(rsp_valid))
      else $error("Unit not busy in the cycle after accepting a transaction.");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_mode)
                                 && $stable(req_operand_a) && $stable(req_operand_b))
      else $error("Stalled request changed.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value)
                                 && $stable(rsp_bad_operand))
      else $error("Stalled result changed.");

endmodule

bind gcd_lcm_unit glu_checker #(
   .OPERAND_BITS(OPERAND_BITS)
) u_glu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_mode       (req_mode),
   .req_operand_a  (req_operand_a),
   .req_operand_b  (req_operand_b),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_value      (rsp_value),
   .rsp_bad_operand(rsp_bad_operand)
);

>>> test/gcd_lcm_unit_test.sv
`timescale 1ns / 1ps

module gcd_lcm_unit_test;

   localparam int OPERAND_BITS = 31;
   localparam int VALUE_BITS = glu_pkg::VALUE_BITS;
   localparam logic MODE_GCD = 1'b0;
   localparam logic MODE_LCM = 1'b1;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct {
      logic [VALUE_BITS-1:0] value;
      logic                  bad_operand;
   } gcd_lcm_result_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_mode;
   logic [OPERAND_BITS-1:0] req_operand_a;
   logic [OPERAND_BITS-1:0] req_operand_b;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [VALUE_BITS-1:0]   rsp_value;
   logic                    rsp_bad_operand;

   gcd_lcm_result_type predicted_results[$];
   int                 error_count = 0;
   bit                 idling_on = 1'b1;

   gcd_lcm_unit #(
      .OPERAND_BITS(OPERAND_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_value(rsp_value),
      .rsp_bad_operand(rsp_bad_operand)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic gcd_lcm_result_type gcd_lcm_of(input logic op_mode,
                                                     input logic [OPERAND_BITS-1:0] a,
                                                     input logic [OPERAND_BITS-1:0] b);
      longint unsigned x;
      longint unsigned y;
      longint unsigned remainder;
      longint unsigned wide_a;
      longint unsigned wide_b;
      gcd_lcm_result_type res;
      res.value = '0;
      res.bad_operand = 1'b0;
      if (a == '0 || b == '0) begin
         res.bad_operand = 1'b1;
         return res;
      end
      wide_a = longint'(a);
      wide_b = longint'(b);
      x = wide_a;
      y = wide_b;
      while (y != 0) begin
         remainder = x % y;
         x = y;
         y = remainder;
      end
      if (op_mode == MODE_LCM) begin
         res.value = VALUE_BITS'((wide_a / x) * wide_b);
      end else begin
         res.value = VALUE_BITS'(x);
      end
      return res;
   endfunction

   task automatic report_error(input string what);
      error_count++;
      $display("[%0t] %s", $time, what);
   endtask

   task automatic send_operands(input logic op_mode,
                                input logic [OPERAND_BITS-1:0] a,
                                input logic [OPERAND_BITS-1:0] b);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= op_mode;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (req_stall);
      predicted_results.push_back(gcd_lcm_of(op_mode, a, b));
   endtask

   task automatic wait_for_all_results();
      req_valid <= 1'b0;
      while (predicted_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_item();
      logic [OPERAND_BITS-1:0] a;
      logic [OPERAND_BITS-1:0] b;
      logic                    op_mode;
      int unsigned             factor;
      op_mode = ($urandom_range(0, 1) == 1) ? MODE_LCM : MODE_GCD;
      factor = $urandom_range(1, 65535);
      case ($urandom_range(0, 19))
         0: begin
            a = '0;
            b = OPERAND_BITS'($urandom());
         end
         1: begin
            a = OPERAND_BITS'($urandom());
            b = '0;
         end
         2, 3, 4, 5: begin
            a = OPERAND_BITS'($urandom());
            b = OPERAND_BITS'($urandom());
         end
         6, 7, 8: begin
            a = OPERAND_BITS'($urandom_range(1, 1000));
            b = OPERAND_BITS'($urandom_range(1, 1000));
         end
         9, 10, 11: begin
            a = OPERAND_BITS'(factor * $urandom_range(1, 32767));
            b = OPERAND_BITS'(factor);
         end
         default: begin
            a = OPERAND_BITS'(factor * $urandom_range(1, 32767));
            b = OPERAND_BITS'(factor * $urandom_range(1, 32767));
         end
      endcase
      send_operands(op_mode, a, b);
   endtask

   task automatic test_directed_cases();
      logic [OPERAND_BITS-1:0] first_ops [11];
      logic [OPERAND_BITS-1:0] second_ops [11];
      logic [OPERAND_BITS-1:0] max_op;
      max_op = '1;
      first_ops = '{'0, '0, max_op, OPERAND_BITS'(1), max_op, max_op, OPERAND_BITS'(1),
                    31'h5555_5555, 31'h4000_0000, OPERAND_BITS'(12), 31'h7FFF_FFFE};
      second_ops = '{'0, max_op, '0, OPERAND_BITS'(1), max_op, max_op - OPERAND_BITS'(1),
                     max_op, 31'h2AAA_AAAA, 31'h3000_0000, OPERAND_BITS'(18),
                     31'h7FFF_FFFD};
      foreach (first_ops[i]) begin
         send_operands(MODE_GCD, first_ops[i], second_ops[i]);
         send_operands(MODE_LCM, first_ops[i], second_ops[i]);
      end
   endtask

   task automatic test_random_operands(input int count);
      repeat (count) send_random_item();
   endtask

   task automatic test_drain_and_resume();
      repeat (4) begin
         repeat (15) send_random_item();
         wait_for_all_results();
      end
   endtask

   task automatic test_without_idling(input int count);
      idling_on = 1'b0;
      repeat (count) send_random_item();
   endtask

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Each accepted transaction on the result side is compared with the oldest prediction.
   initial begin : result_checker
      gcd_lcm_result_type wanted;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               report_error($sformatf("unexpected result: value %0d, bad_operand %0b",
                                      rsp_value, rsp_bad_operand));
            end else begin
               wanted = predicted_results.pop_front();
               if (rsp_value !== wanted.value) begin
                  report_error($sformatf("value: expected %0d, got %0d",
                                         wanted.value, rsp_value));
               end
               if (rsp_bad_operand !== wanted.bad_operand) begin
                  report_error($sformatf("bad_operand: expected %0b, got %0b",
                                         wanted.bad_operand, rsp_bad_operand));
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("gcd_lcm_unit: mismatch");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_GCD;
      req_operand_a <= '0;
      req_operand_b <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_operands(450);
      test_drain_and_resume();
      test_without_idling(150);
      wait_for_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("gcd_lcm_unit: match");
      end else begin
         $display("gcd_lcm_unit: mismatch");
      end
      $finish;
   end

endmodule
